// ===== src/mrpt_pkg.sv =====
// Shared types and constants for the Miller-Rabin primality tester.
package mrpt_pkg;

    localparam int BASE_W    = 32;
    localparam int BASE_REGS = 4;
    localparam int CAND_W    = 32;
    localparam int CNT_W     = 3;
    localparam int RCNT_W    = $clog2(BASE_W);

    // Configuration register indexes
    localparam logic [2:0] REG_BASE_COUNT = 3'd0;
    localparam logic [2:0] REG_BASE_ZERO  = 3'd1;
    localparam logic [2:0] REG_BASE_ONE   = 3'd2;
    localparam logic [2:0] REG_BASE_TWO   = 3'd3;
    localparam logic [2:0] REG_BASE_THREE = 3'd4;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0]  RST_BASE_COUNT = 3'd3;
    localparam logic [BASE_W-1:0] RST_BASE_ZERO  = 32'd2;
    localparam logic [BASE_W-1:0] RST_BASE_ONE   = 32'd7;
    localparam logic [BASE_W-1:0] RST_BASE_TWO   = 32'd61;
    localparam logic [BASE_W-1:0] RST_BASE_THREE = 32'd2;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SPLIT  = 10'b00_0000_0010,
        ST_BASE   = 10'b00_0000_0100,
        ST_REDUCE = 10'b00_0000_1000,
        ST_POW    = 10'b00_0001_0000,
        ST_MUL    = 10'b00_0010_0000,
        ST_POWA   = 10'b00_0100_0000,
        ST_POWX   = 10'b00_1000_0000,
        ST_SQ     = 10'b01_0000_0000,
        ST_SQCHK  = 10'b10_0000_0000
    } t_state;

endpackage

// ===== src/miller_rabin_primality_test.sv =====
// Miller-Rabin primality tester built around one shared shift-and-add modular multiplier.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+------------------------------
//  command   | start, busy, i_candidate[31:0]                | item taken when start & !busy
//  result    | o_done, o_is_prime                            | one-cycle strobe, no back-pressure
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index[2:0],   | write when valid & ready;
//            | i_cfg_data[31:0]                              | ready is always high
//
// Trivial candidates (two, below two, even) are answered without leaving idle. An odd
// candidate strips the trailing zeros of n-1 one at a time in the split, then per base
// fetches the base and reduces it mod n bit by bit, then takes up to 2*log2(n) modular
// products for the power and k more for the squarings. The shared multiplier stops once
// the remaining bits of its second operand are zero, so a product costs more for a
// longer operand; a composite usually stops after its first base. busy stays high for
// the whole of an odd item above two; its result strobe is given as busy falls, and a
// new item may be started in that same cycle. Trivial items never raise busy. Reset is
// synchronous, active low; it returns the sequencer to idle and reloads the witness
// bases 2, 7, 61, 2 with a count of three. The receiver cannot stall: o_done is high
// for exactly one cycle per item.
module miller_rabin_primality_test
    import mrpt_pkg::*;
#(
    parameter int NUM_WIDTH = 32,
    parameter int MAX_BASES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic [CAND_W-1:0] i_candidate,
    // result channel
    output logic              o_done,
    output logic              o_is_prime,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [BASE_W-1:0] i_cfg_data
);

    localparam int NW = NUM_WIDTH;
    localparam int KW = $clog2(NW);
    localparam int LIM_I = (MAX_BASES < BASE_REGS) ? MAX_BASES : BASE_REGS;
    localparam logic [CNT_W-1:0] LIM = CNT_W'(LIM_I);
    localparam logic [NW-1:0] ONE = NW'(1);
    localparam logic [NW-1:0] TWO = NW'(2);

    // Add two residues mod m; both inputs are below m.
    function automatic logic [NW-1:0] addmod(input logic [NW-1:0] a,
                                             input logic [NW-1:0] b,
                                             input logic [NW-1:0] m);
        logic [NW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[NW-1:0];
    endfunction

    // configuration registers
    logic [CNT_W-1:0]  r_base_count;
    logic [BASE_W-1:0] r_bases [BASE_REGS];

    // sequencer and datapath registers
    t_state            r_state, n_state;
    t_state            r_ret, n_ret;
    logic [NW-1:0]     r_n, n_n;        // candidate
    logic [NW-1:0]     r_m, n_m;        // odd part of n-1
    logic [KW-1:0]     r_k, n_k;        // power of two in n-1
    logic [KW-1:0]     r_j, n_j;        // squaring count
    logic [CNT_W-1:0]  r_idx, n_idx;    // current base
    logic [BASE_W-1:0] r_bsh, n_bsh;    // base, shifted out MSB first
    logic [RCNT_W-1:0] r_rcnt, n_rcnt;
    logic [NW-1:0]     r_rem, n_rem;    // base mod n under way
    logic [NW-1:0]     r_pacc, n_pacc;  // power accumulator
    logic [NW-1:0]     r_px, n_px;      // power base, then the squared value
    logic [NW-1:0]     r_e, n_e;        // exponent bits still to use
    logic [NW-1:0]     r_y, n_y;        // last square
    logic [NW-1:0]     r_mx, n_mx;      // multiplier: doubled operand
    logic [NW-1:0]     r_my, n_my;      // multiplier: remaining bits
    logic [NW-1:0]     r_macc, n_macc;  // multiplier: product
    logic              r_done, n_done;
    logic              r_prime, n_prime;

    logic [2*CAND_W-1:0] w_cand_ext;
    logic [NW-1:0]       w_cand;
    logic [CNT_W-1:0]    w_count;
    logic [NW:0]         w_rsh;

    assign w_cand_ext = {{CAND_W{1'b0}}, i_candidate};
    assign w_cand     = w_cand_ext[NW-1:0];
    // saturate the base count to the usable registers
    assign w_count    = (r_base_count > LIM) ? LIM : r_base_count;
    // one restoring step of base mod n
    assign w_rsh      = {r_rem, r_bsh[BASE_W-1]};

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_is_prime  = r_prime;
    assign o_cfg_ready = 1'b1;

    // Configuration writes, taken only while idle by user contract; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_count <= RST_BASE_COUNT;
            r_bases[0]   <= RST_BASE_ZERO;
            r_bases[1]   <= RST_BASE_ONE;
            r_bases[2]   <= RST_BASE_TWO;
            r_bases[3]   <= RST_BASE_THREE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE_COUNT: r_base_count <= i_cfg_data[CNT_W-1:0];
                REG_BASE_ZERO:  r_bases[0]   <= i_cfg_data;
                REG_BASE_ONE:   r_bases[1]   <= i_cfg_data;
                REG_BASE_TWO:   r_bases[2]   <= i_cfg_data;
                REG_BASE_THREE: r_bases[3]   <= i_cfg_data;
                default: ;  // unused indexes drop the write
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_n     = r_n;
        n_m     = r_m;
        n_k     = r_k;
        n_j     = r_j;
        n_idx   = r_idx;
        n_bsh   = r_bsh;
        n_rcnt  = r_rcnt;
        n_rem   = r_rem;
        n_pacc  = r_pacc;
        n_px    = r_px;
        n_e     = r_e;
        n_y     = r_y;
        n_mx    = r_mx;
        n_my    = r_my;
        n_macc  = r_macc;
        n_done  = 1'b0;
        n_prime = r_prime;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_n = w_cand;
                    n_m = w_cand - ONE;
                    n_k = '0;
                    if (w_cand == TWO) begin
                        n_done  = 1'b1;
                        n_prime = 1'b1;
                    end else if (w_cand < TWO || !w_cand[0]) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                    end else begin
                        n_state = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                // strip trailing zeros of n-1, one a cycle
                if (!r_m[0]) begin
                    n_m = r_m >> 1;
                    n_k = r_k + KW'(1);
                end else begin
                    n_idx   = '0;
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                if (r_idx >= w_count) begin
                    n_done  = 1'b1;
                    n_prime = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_bsh   = r_bases[r_idx[1:0]];
                    n_rem   = '0;
                    n_rcnt  = '0;
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                n_rem  = (w_rsh >= {1'b0, r_n}) ? NW'(w_rsh - {1'b0, r_n}) : w_rsh[NW-1:0];
                n_bsh  = r_bsh << 1;
                n_rcnt = r_rcnt + RCNT_W'(1);
                if (r_rcnt == RCNT_W'(BASE_W - 1)) begin
                    if (n_rem == '0) begin
                        // base is a multiple of n: skip the round
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = ST_BASE;
                    end else begin
                        n_pacc  = ONE;
                        n_px    = n_rem;
                        n_e     = r_m;
                        n_state = ST_POW;
                    end
                end
            end
            ST_POW: begin
                n_macc = '0;
                if (r_e == '0) begin
                    n_px    = r_pacc;
                    n_j     = '0;
                    n_state = ST_SQ;
                end else if (r_e[0]) begin
                    n_mx    = r_pacc;
                    n_my    = r_px;
                    n_ret   = ST_POWA;
                    n_state = ST_MUL;
                end else begin
                    n_mx    = r_px;
                    n_my    = r_px;
                    n_ret   = ST_POWX;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // shared shift-and-add multiplier, LSB of the second operand first
                if (r_my == '0) begin
                    n_state = r_ret;
                end else begin
                    if (r_my[0]) begin
                        n_macc = addmod(r_macc, r_mx, r_n);
                    end
                    n_mx = addmod(r_mx, r_mx, r_n);
                    n_my = r_my >> 1;
                end
            end
            ST_POWA: begin
                n_pacc  = r_macc;
                n_macc  = '0;
                n_mx    = r_px;
                n_my    = r_px;
                n_ret   = ST_POWX;
                n_state = ST_MUL;
            end
            ST_POWX: begin
                n_px    = r_macc;
                n_e     = r_e >> 1;
                n_state = ST_POW;
            end
            ST_SQ: begin
                n_macc = '0;
                if (r_j == r_k) begin
                    if (r_y != ONE) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = ST_BASE;
                    end
                end else begin
                    n_mx    = r_px;
                    n_my    = r_px;
                    n_ret   = ST_SQCHK;
                    n_state = ST_MUL;
                end
            end
            ST_SQCHK: begin
                n_y = r_macc;
                // a square root of one other than plus or minus one
                if (r_macc == ONE && r_px != ONE && r_px != (r_n - ONE)) begin
                    n_done  = 1'b1;
                    n_prime = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_px    = r_macc;
                    n_j     = r_j + KW'(1);
                    n_state = ST_SQ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_done  <= 1'b0;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_done  <= n_done;
            r_prime <= n_prime;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_m    <= n_m;
        r_k    <= n_k;
        r_j    <= n_j;
        r_idx  <= n_idx;
        r_bsh  <= n_bsh;
        r_rcnt <= n_rcnt;
        r_rem  <= n_rem;
        r_pacc <= n_pacc;
        r_px   <= n_px;
        r_e    <= n_e;
        r_y    <= n_y;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_macc <= n_macc;
    end

endmodule

// ===== verif/tb_miller_rabin_primality_test.sv =====
// Self-checking testbench for the Miller-Rabin primality tester: directed and random candidates.
module tb_miller_rabin_primality_test
    import mrpt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of witness bases the block is built for; counts above it saturate
    localparam int MAX_WIT = 4;

    // One pending verdict: the candidate that was taken and the answer it must give
    typedef struct {
        logic [CAND_W-1:0] cand;
        logic              prime;
    } t_verdict;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    logic [CAND_W-1:0] cand      = '0;
    logic              done;
    logic              is_prime;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = REG_BASE_COUNT;
    logic [BASE_W-1:0] cfg_data  = '0;

    // Shadow copy of the witness registers, updated as each write is taken
    logic [CNT_W-1:0]  wit_count;
    logic [BASE_W-1:0] wit_base [BASE_REGS];

    logic [CAND_W-1:0] cand_q [$];     // items waiting to be offered
    t_verdict          verdict_q [$];  // verdicts owed by the block, oldest first
    logic [CAND_W-1:0] hard_cases [9]; // strong pseudoprimes and Carmichael numbers

    int unsigned send_idle_pct = 0;
    int unsigned fails         = 0;
    bit          took          = 1'b0;

    miller_rabin_primality_test #(
        .NUM_WIDTH (CAND_W),
        .MAX_BASES (MAX_WIT)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_candidate (cand),
        .o_done      (done),
        .o_is_prime  (is_prime),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // (x * y) mod n by shift-and-add; operands stay below n, so 33 bits suffice
    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
        logic [63:0] acc;
        acc = '0;
        while (y != 0) begin
            if (y[0]) begin
                acc = acc + x;
                if (acc >= n) acc = acc - n;
            end
            y = y >> 1;
            x = x + x;
            if (x >= n) x = x - n;
        end
        return acc;
    endfunction

    // (x ^ e) mod n by square-and-multiply
    function automatic logic [63:0] powmod(logic [63:0] x, logic [63:0] e, logic [63:0] n);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, x, n);
            e = e >> 1;
            x = mulmod(x, x, n);
        end
        return acc;
    endfunction

    // Verdict of the strong-probable-prime test for the given witness set
    function automatic logic mr_verdict(logic [CAND_W-1:0] c, int unsigned rounds,
                                        logic [BASE_W-1:0] wit [BASE_REGS]);
        logic [63:0] n, m, a, x, y;
        int unsigned k;
        n = c;
        if (n == 2) return 1'b1;
        if (n < 2 || !n[0]) return 1'b0;
        // split n-1 into an odd part and a power of two
        m = n - 1;
        k = 0;
        while (!m[0]) begin
            m = m >> 1;
            k++;
        end
        // saturate the round count to the build limit and the register file
        if (rounds > MAX_WIT)   rounds = MAX_WIT;
        if (rounds > BASE_REGS) rounds = BASE_REGS;
        for (int i = 0; i < rounds; i++) begin
            a = wit[i] % n;
            // a base that is a multiple of the candidate proves nothing: skip it
            if (a == 0) continue;
            x = powmod(a, m, n);
            y = '0;
            for (int j = 0; j < k; j++) begin
                y = mulmod(x, x, n);
                // a square root of one other than +-1 exposes a composite
                if (y == 1 && x != 1 && x != n - 1) return 1'b0;
                x = y;
            end
            if (y != 1) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Next odd prime at or above the seed, found with the exact 32-bit witness set
    function automatic logic [CAND_W-1:0] find_prime(logic [CAND_W-1:0] seed);
        logic [BASE_W-1:0] std_wit [BASE_REGS];
        logic [CAND_W-1:0] c;
        std_wit = '{32'd2, 32'd7, 32'd61, 32'd2};
        c = seed | 32'd1;
        if (c < 3) c = 32'd3;
        while (!mr_verdict(c, 3, std_wit)) c = c + 32'd2;
        return c;
    endfunction

    // Random candidate, biased towards primes and hard composites so that the
    // squaring chain runs to its end far more often than plain random odd numbers allow
    function automatic logic [CAND_W-1:0] rand_candidate();
        logic [CAND_W-1:0] c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        c    = $urandom;
        if (pick < 15)      c = find_prime(c);
        else if (pick < 30) c = find_prime(c & 32'h0000_FFFF);
        else if (pick < 40) c = find_prime(c & 32'h0000_FFFF) * find_prime($urandom_range(3, 65521));
        else if (pick < 50) c = hard_cases[$urandom_range(0, 8)];
        else if (pick < 65) c = c | 32'd1;
        else if (pick < 80) c = (c & 32'h0000_0FFF) | 32'd1;
        return c;
    endfunction

    // Write one register while the block is idle and mirror it in the shadow copy
    task automatic write_reg(logic [2:0] idx, logic [BASE_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_BASE_COUNT: wit_count   = val[CNT_W-1:0];
            REG_BASE_ZERO:  wit_base[0] = val;
            REG_BASE_ONE:   wit_base[1] = val;
            REG_BASE_TWO:   wit_base[2] = val;
            REG_BASE_THREE: wit_base[3] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every queued item is taken and every verdict has come back
    task automatic drain();
        do @(negedge clk);
        while (cand_q.size() != 0 || verdict_q.size() != 0 || start || busy);
    endtask

    task automatic queue_random(int unsigned count);
        for (int i = 0; i < count; i++) cand_q.push_back(rand_candidate());
    endtask

    // Driver: offer the next item on the falling edge, hold it until taken
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // hold: the block has not taken the current item yet
        end else if (cand_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            start <= 1'b1;
            cand  <= cand_q[0];
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: check each verdict strobe, then record any item taken at this edge
    always @(posedge clk) begin : monitor
        t_verdict owed;
        if (rst_n && done) begin
            if (verdict_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("[%0t] unexpected verdict is_prime=%0b", $realtime, is_prime);
            end else begin
                owed = verdict_q.pop_front();
                if (is_prime !== owed.prime) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] candidate %0d: is_prime expected %0b, got %0b",
                                 $realtime, owed.cand, owed.prime, is_prime);
                end
            end
        end
        took = rst_n && start && !busy;
        if (took) begin
            owed.cand  = cand;
            owed.prime = mr_verdict(cand, wit_count, wit_base);
            verdict_q.push_back(owed);
            void'(cand_q.pop_front());
        end
    end

    // Guard against a hang
    initial begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        wit_count   = RST_BASE_COUNT;
        wit_base[0] = RST_BASE_ZERO;
        wit_base[1] = RST_BASE_ONE;
        wit_base[2] = RST_BASE_TWO;
        wit_base[3] = RST_BASE_THREE;
        hard_cases  = '{32'd2047, 32'd3277, 32'd4033, 32'd4681, 32'd8321, 32'd561,
                        32'd1373653, 32'd25326001, 32'd3215031751};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset witnesses 2, 7, 61, no idling: trivial cases, field extremes,
        // bases that vanish mod the candidate (7, 61) or reduce to one (3, 5),
        // and composites that fool single bases
        send_idle_pct = 0;
        foreach (hard_cases[i]) cand_q.push_back(hard_cases[i]);
        cand_q.push_back(32'd0);
        cand_q.push_back(32'd1);
        cand_q.push_back(32'd2);
        cand_q.push_back(32'd3);
        cand_q.push_back(32'd4);
        cand_q.push_back(32'd5);
        cand_q.push_back(32'd7);
        cand_q.push_back(32'd9);
        cand_q.push_back(32'd13);
        cand_q.push_back(32'd61);
        cand_q.push_back(32'd65537);
        cand_q.push_back(32'h7FFF_FFFF);
        cand_q.push_back(32'd4294967291);
        cand_q.push_back(32'hFFFF_FFFF);
        cand_q.push_back(32'hFFFF_FFFE);
        cand_q.push_back(32'h8000_0000);
        cand_q.push_back(32'h8000_0001);
        drain();

        // Four bases at the extremes (zero, one, all ones, top bit), sender mostly idle
        send_idle_pct = 74;
        write_reg(REG_BASE_COUNT, 32'd4);
        write_reg(REG_BASE_ZERO,  32'd0);
        write_reg(REG_BASE_ONE,   32'd1);
        write_reg(REG_BASE_TWO,   32'hFFFF_FFFF);
        write_reg(REG_BASE_THREE, 32'h8000_0000);
        cand_q.push_back(32'hFFFF_FFFF);
        cand_q.push_back(32'd3);
        cand_q.push_back(32'd5);
        queue_random(12);
        drain();

        // No rounds at all: every odd candidate above two passes
        send_idle_pct = 29;
        write_reg(REG_BASE_COUNT, 32'd0);
        cand_q.push_back(32'd9);
        cand_q.push_back(32'hFFFF_FFFF);
        queue_random(10);
        drain();

        // Count of seven saturates; random witnesses, no idling
        send_idle_pct = 0;
        write_reg(REG_BASE_COUNT, 32'd7);
        write_reg(REG_BASE_ZERO,  $urandom);
        write_reg(REG_BASE_ONE,   $urandom);
        write_reg(REG_BASE_TWO,   $urandom);
        write_reg(REG_BASE_THREE, $urandom);
        queue_random(15);
        drain();

        // Base two alone: its strong pseudoprimes slip through as prime
        send_idle_pct = 74;
        write_reg(REG_BASE_COUNT, 32'd1);
        write_reg(REG_BASE_ZERO,  32'd2);
        for (int i = 0; i < 5; i++) cand_q.push_back(hard_cases[i]);
        queue_random(10);
        drain();

        // Exact witnesses back, count of five saturates, random fourth base
        send_idle_pct = 29;
        write_reg(REG_BASE_COUNT, 32'd5);
        write_reg(REG_BASE_ONE,   32'd7);
        write_reg(REG_BASE_TWO,   32'd61);
        write_reg(REG_BASE_THREE, $urandom);
        queue_random(15);
        drain();

        // Wait for any stray strobe, then settle the verdict
        repeat (50) @(negedge clk);
        fails += verdict_q.size();
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
